// ----- src/btmx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants of the maximum-XOR trie unit
// Transaction kinds, field widths, default sizes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package btmx_pkg;

  // Default sizes
  localparam int KEY_BITS_DEF  = 31;
  localparam int MAX_NODES_DEF = 65536;
  localparam int LOG_DEPTH_DEF = 8192;

  // Field widths on the stream ports
  localparam int KIND_W       = 3;
  localparam int KEY_W        = 31;
  localparam int IN_TDATA_W   = ((KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((KEY_W + 7) / 8) * 8;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_PERM = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_TEMP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UNDO     = 3'd4;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK_INS,
    ST_WALK_QRY,
    ST_CHECK,
    ST_BUILD,
    ST_BUILD_LAST,
    ST_UNDO_LOG,
    ST_UNDO_NODE,
    ST_UNDO_WR,
    ST_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // latch the incoming transaction
    logic start;       // set up walk registers for a new transaction
    logic clear;       // empty the trie
    logic walk_ins;    // one level of the insert path search
    logic walk_qry;    // one level of the query walk
    logic set_full;    // refuse the insert
    logic build;       // write one node of a new path
    logic build_last;  // write the leaf node of a new path
    logic undo_node;   // take the logged node address
    logic undo_wr;     // clear the logged link
    logic undo_done;   // drop temporaries
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              link_zero;  // selected child link is empty
    logic              lvl_zero;   // walk is at the lowest level
    logic              chk_full;   // new path does not fit
    logic              log_end;    // undo log fully replayed
    logic              out_full;   // output register holds a result
  } sts_t;

endpackage

// ----- src/btmx_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_ctrl: sequencer of the maximum-XOR trie unit
// Decodes each transaction and steps the datapath through walk, build, undo
// replay and result hand-off.
// ----------------------------------------------------------------------------
module btmx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_tready,
  input  btmx_pkg::sts_t   sts_i,
  output btmx_pkg::cmd_t   cmd_o
);

  btmx_pkg::state_t state_r;
  btmx_pkg::state_t state_nxt;
  logic             out_free;

  assign out_free = !sts_i.out_full || out_tready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btmx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      btmx_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = btmx_pkg::ST_DECODE;
      end
      btmx_pkg::ST_DECODE: begin
        case (sts_i.kind)
          btmx_pkg::KIND_INS_PERM: state_nxt = btmx_pkg::ST_WALK_INS;
          btmx_pkg::KIND_INS_TEMP: state_nxt = btmx_pkg::ST_WALK_INS;
          btmx_pkg::KIND_QUERY:    state_nxt = btmx_pkg::ST_WALK_QRY;
          btmx_pkg::KIND_UNDO:     state_nxt = btmx_pkg::ST_UNDO_LOG;
          default:                 state_nxt = btmx_pkg::ST_RESP;
        endcase
      end
      btmx_pkg::ST_WALK_INS: begin
        if (sts_i.link_zero) begin
          state_nxt = btmx_pkg::ST_CHECK;
        end else if (sts_i.lvl_zero) begin
          state_nxt = btmx_pkg::ST_RESP;
        end
      end
      btmx_pkg::ST_WALK_QRY: begin
        if (sts_i.lvl_zero) state_nxt = btmx_pkg::ST_RESP;
      end
      btmx_pkg::ST_CHECK: begin
        state_nxt = sts_i.chk_full ? btmx_pkg::ST_RESP : btmx_pkg::ST_BUILD;
      end
      btmx_pkg::ST_BUILD: begin
        if (sts_i.lvl_zero) state_nxt = btmx_pkg::ST_BUILD_LAST;
      end
      btmx_pkg::ST_BUILD_LAST: state_nxt = btmx_pkg::ST_RESP;
      btmx_pkg::ST_UNDO_LOG: begin
        state_nxt = sts_i.log_end ? btmx_pkg::ST_RESP : btmx_pkg::ST_UNDO_NODE;
      end
      btmx_pkg::ST_UNDO_NODE: state_nxt = btmx_pkg::ST_UNDO_WR;
      btmx_pkg::ST_UNDO_WR:   state_nxt = btmx_pkg::ST_UNDO_LOG;
      btmx_pkg::ST_RESP: begin
        if (out_free) state_nxt = btmx_pkg::ST_IDLE;
      end
      default: state_nxt = btmx_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      btmx_pkg::ST_IDLE: begin
        in_tready    = 1'b1;
        cmd_o.accept = in_tvalid;
      end
      btmx_pkg::ST_DECODE: begin
        cmd_o.start = 1'b1;
        cmd_o.clear = (sts_i.kind == btmx_pkg::KIND_CLEAR);
      end
      btmx_pkg::ST_WALK_INS:   cmd_o.walk_ins   = 1'b1;
      btmx_pkg::ST_WALK_QRY:   cmd_o.walk_qry   = 1'b1;
      btmx_pkg::ST_CHECK:      cmd_o.set_full   = sts_i.chk_full;
      btmx_pkg::ST_BUILD:      cmd_o.build      = 1'b1;
      btmx_pkg::ST_BUILD_LAST: cmd_o.build_last = 1'b1;
      btmx_pkg::ST_UNDO_LOG:   cmd_o.undo_done  = sts_i.log_end;
      btmx_pkg::ST_UNDO_NODE:  cmd_o.undo_node  = 1'b1;
      btmx_pkg::ST_UNDO_WR:    cmd_o.undo_wr    = 1'b1;
      btmx_pkg::ST_RESP:       cmd_o.out_load   = out_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- src/btmx_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_dpath: node memory, undo log and walk registers of the trie unit
// Holds the trie links, the node and log counters, the per-level walk
// registers and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module btmx_dpath #(
  parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
  parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF,
  parameter int LOG_DEPTH = btmx_pkg::LOG_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  btmx_pkg::cmd_t              cmd_i,
  output btmx_pkg::sts_t              sts_o,
  input  logic [btmx_pkg::KIND_W-1:0] in_kind,
  input  logic [btmx_pkg::KEY_W-1:0]  in_key,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [btmx_pkg::KEY_W-1:0]  out_max_xor,
  output logic                        out_pool_full
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ENT_W  = 2 * NODE_W;
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int LOG_AW = $clog2(LOG_DEPTH);
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int LOGE_W = NODE_W + 1;
  localparam int CHK_W  = NODE_W + 1;
  localparam int LCHK_W = CNT_W + 1;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

  // Transaction registers
  logic [btmx_pkg::KIND_W-1:0] kind_r;
  logic [KEY_BITS-1:0]         key_r;

  // Walk registers
  logic [NODE_W-1:0]   u_r, u_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [KEY_BITS-1:0] res_r, res_nxt;
  logic                full_r, full_nxt;
  logic                temp_r, temp_nxt;
  logic                first_r, first_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                side_r, side_nxt;

  // Trie bookkeeping
  logic [NODE_W-1:0] kept_r, kept_nxt;
  logic [NODE_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ENT_W-1:0]  root_r, root_nxt;

  // Output register
  logic                       out_valid_r, out_valid_nxt;
  logic [btmx_pkg::KEY_W-1:0] out_data_r;
  logic                       out_full_r;

  // Memories
  logic [ENT_W-1:0]  node_mem [MAX_NODES];
  logic [ENT_W-1:0]  node_rdata_r;
  logic [LOGE_W-1:0] log_mem [LOG_DEPTH];
  logic [LOGE_W-1:0] log_rdata_r;

  // Combinational datapath
  logic [ENT_W-1:0]  cur_links;
  logic [NODE_W-1:0] link0, link1, sel_link, oth_link, new_node, build_other;
  logic              key_bit, lvl_zero, node_over, log_over, qry_hit;
  logic [ENT_W-1:0]  build_wdata, undo_wdata, node_wdata;
  logic              node_wr, node_we, root_we, log_we;
  logic [LOGE_W-1:0] log_wdata;

  // Links of the current node: root from registers, others from memory
  assign cur_links = (u_r == '0) ? root_r : node_rdata_r;
  assign link0     = cur_links[NODE_W-1:0];
  assign link1     = cur_links[ENT_W-1:NODE_W];
  assign key_bit   = key_r[lvl_r];
  assign sel_link  = key_bit ? link1 : link0;
  assign oth_link  = key_bit ? link0 : link1;
  assign lvl_zero  = (lvl_r == '0);
  assign qry_hit   = (oth_link != '0);

  // Room for a path of lvl+1 new nodes
  assign node_over = ({1'b0, used_r} + CHK_W'(lvl_r) + CHK_W'(1))
                     > CHK_W'(MAX_NODES - 1);
  assign log_over  = ({1'b0, count_r} + LCHK_W'(lvl_r) + LCHK_W'(1))
                     > LCHK_W'(LOG_DEPTH);

  // Node writes: chain the new path, clear an undone link
  assign new_node    = used_r + NODE_W'(1);
  assign build_other = first_r ? oth_link : '0;
  assign build_wdata = key_bit ? {new_node, build_other} : {build_other, new_node};
  assign undo_wdata  = side_r ? {NODE_W'(0), link0} : {link1, NODE_W'(0)};

  always_comb begin
    if (cmd_i.build) begin
      node_wdata = build_wdata;
    end else if (cmd_i.undo_wr) begin
      node_wdata = undo_wdata;
    end else begin
      node_wdata = '0;
    end
  end

  assign node_wr   = cmd_i.build || cmd_i.build_last || cmd_i.undo_wr;
  assign node_we   = node_wr && (u_r != '0);
  assign root_we   = node_wr && (u_r == '0);
  assign log_we    = cmd_i.build && temp_r;
  assign log_wdata = {u_r, key_bit};

  // Next values of walk and bookkeeping registers
  always_comb begin
    u_nxt     = u_r;
    lvl_nxt   = lvl_r;
    res_nxt   = res_r;
    full_nxt  = full_r;
    temp_nxt  = temp_r;
    first_nxt = first_r;
    idx_nxt   = idx_r;
    side_nxt  = side_r;
    kept_nxt  = kept_r;
    used_nxt  = used_r;
    count_nxt = count_r;
    root_nxt  = root_r;

    if (cmd_i.start) begin
      u_nxt     = '0;
      lvl_nxt   = LVL_TOP;
      res_nxt   = '0;
      full_nxt  = 1'b0;
      first_nxt = 1'b1;
      idx_nxt   = '0;
      temp_nxt  = (kind_r == btmx_pkg::KIND_INS_TEMP) || (used_r != kept_r)
                  || (count_r != '0);
    end
    // Empty the trie
    if (cmd_i.clear) begin
      kept_nxt  = '0;
      used_nxt  = '0;
      count_nxt = '0;
      root_nxt  = '0;
    end
    // Follow the existing part of the key's path
    if (cmd_i.walk_ins && !(sel_link == '0)) begin
      u_nxt = sel_link;
      if (!lvl_zero) lvl_nxt = lvl_r - LVL_W'(1);
    end
    // Prefer the child whose bit differs from the key
    if (cmd_i.walk_qry) begin
      u_nxt = qry_hit ? oth_link : sel_link;
      if (qry_hit) res_nxt = res_r | (KEY_BITS'(1) << lvl_r);
      if (!lvl_zero) lvl_nxt = lvl_r - LVL_W'(1);
    end
    if (cmd_i.set_full) full_nxt = 1'b1;
    // Append one node to the new path
    if (cmd_i.build) begin
      u_nxt     = new_node;
      used_nxt  = new_node;
      first_nxt = 1'b0;
      if (!temp_r) kept_nxt = kept_r + NODE_W'(1);
      if (temp_r) count_nxt = count_r + CNT_W'(1);
      if (!lvl_zero) lvl_nxt = lvl_r - LVL_W'(1);
    end
    if (root_we) root_nxt = node_wdata;
    // Replay the undo log
    if (cmd_i.undo_node) begin
      u_nxt    = log_rdata_r[LOGE_W-1:1];
      side_nxt = log_rdata_r[0];
    end
    if (cmd_i.undo_wr) idx_nxt = idx_r + CNT_W'(1);
    if (cmd_i.undo_done) begin
      count_nxt = '0;
      used_nxt  = kept_r;
    end
  end

  // Output register handshake
  always_comb begin
    if (cmd_i.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r      <= '0;
      used_r      <= '0;
      count_r     <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      kept_r      <= kept_nxt;
      used_r      <= used_nxt;
      count_r     <= count_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      kind_r <= in_kind;
      key_r  <= KEY_BITS'(in_key);
    end
    if (cmd_i.out_load) begin
      out_data_r <= btmx_pkg::KEY_W'(res_r);
      out_full_r <= full_r;
    end
    u_r     <= u_nxt;
    lvl_r   <= lvl_nxt;
    res_r   <= res_nxt;
    full_r  <= full_nxt;
    temp_r  <= temp_nxt;
    first_r <= first_nxt;
    idx_r   <= idx_nxt;
    side_r  <= side_nxt;
  end

  // Node memory: read the node that becomes current next cycle
  always_ff @(posedge clk) begin
    if (node_we) node_mem[u_r] <= node_wdata;
    node_rdata_r <= node_mem[u_nxt];
  end

  // Undo log memory
  always_ff @(posedge clk) begin
    if (log_we) log_mem[count_r[LOG_AW-1:0]] <= log_wdata;
    log_rdata_r <= log_mem[idx_r[LOG_AW-1:0]];
  end

  assign sts_o.kind      = kind_r;
  assign sts_o.link_zero = (sel_link == '0);
  assign sts_o.lvl_zero  = lvl_zero;
  assign sts_o.chk_full  = node_over || (temp_r && log_over);
  assign sts_o.log_end   = (idx_r == count_r);
  assign sts_o.out_full  = out_valid_r;

  assign out_tvalid    = out_valid_r;
  assign out_max_xor   = out_data_r;
  assign out_pool_full = out_full_r;

  // Temporary nodes always sit above the permanent ones
  a_used_ge_kept: assert property (@(posedge clk) disable iff (!rst_n)
    used_r >= kept_r) else $error("node count below permanent count");

  // Logged links imply temporary nodes exist
  a_log_has_temp: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (used_r > kept_r)) else $error("log without temporaries");

  // Log never exceeds its depth
  a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LOG_DEPTH)) else $error("undo log overflow");

  // A build step only writes an allocated node
  a_build_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.build |-> (u_r <= used_r)) else $error("build writes unallocated node");

endmodule

// ----- src/binary_trie_max_xor_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit: bitwise trie with maximum-XOR query
// Clear, permanent insert, temporary insert, query and undo of temporaries
// over a node memory of two child links per node, one transaction at a time.
// ----------------------------------------------------------------------------
// One transaction is processed at a time, and each one returns exactly one
// result. The node memory is read once per trie level, and a query visits one
// node per level; an insert walks the existing part of the path one level per
// cycle and then writes one new node per cycle. Clear and unknown kinds go
// straight to the result. Undo replays its log with a read-modify-write of
// the node memory, stepping through the log, node and write states for each
// logged link. A finished result waits in the output register while the next
// transaction is accepted; if that result is still waiting when the next one
// is ready, the unit holds until it is taken. The trie needs no clearing pass
// after reset: only the root's links sit in flip-flops.
module binary_trie_max_xor_unit #(
  parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
  parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF,
  parameter int LOG_DEPTH = btmx_pkg::LOG_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [btmx_pkg::IN_TDATA_W-1:0]  in_tdata,   // [30:0] key
  input  logic [btmx_pkg::KIND_W-1:0]      in_tuser,   // [2:0] kind
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [btmx_pkg::OUT_TDATA_W-1:0] out_tdata,  // [30:0] max_xor
  output logic [0:0]                       out_tuser   // [0] pool_full
);

  btmx_pkg::cmd_t             cmd;
  btmx_pkg::sts_t             sts;
  logic [btmx_pkg::KEY_W-1:0] max_xor;
  logic                       pool_full;

  // Sequencer
  btmx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Trie storage and walk logic
  btmx_dpath #(
    .KEY_BITS  (KEY_BITS),
    .MAX_NODES (MAX_NODES),
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_kind       (in_tuser),
    .in_key        (in_tdata[btmx_pkg::KEY_W-1:0]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_max_xor   (max_xor),
    .out_pool_full (pool_full)
  );

  // Pack the result transaction
  assign out_tdata = btmx_pkg::OUT_TDATA_W'(max_xor);
  assign out_tuser = pool_full;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the maximum-XOR trie unit
// Streams clear, insert, query and undo transactions into the unit with random
// gaps and output stalls. A behavioral copy of the trie predicts every result,
// and each result is checked in order against the oldest prediction. A long
// run of temporaries fills the undo log to reach the refusal path.
// ----------------------------------------------------------------------------
module testbench;
  import btmx_pkg::*;

  localparam int TRIE_NODES = MAX_NODES_DEF;
  localparam int LOG_SLOTS  = LOG_DEPTH_DEF;
  localparam int KEY_LEN    = KEY_BITS_DEF;
  localparam int RANDOM_OPS = 270;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } trie_op_t;

  typedef struct packed {
    logic [KEY_W-1:0] max_xor;
    logic             pool_full;
  } trie_result_t;

  // Clock, reset and bus signals
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  // Handshake bookkeeping
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic hold_off  = 1'b0;
  int   send_gap  = 0;
  bit   send_burst = 1'b0;
  int   recv_stall = 0;
  int   accepted_items = 0;
  int   mismatch_count = 0;
  int   counted_ops = 0;

  trie_op_t         pending_ops[$];
  trie_result_t     results_due[$];
  logic [KEY_W-1:0] seen_keys[$];

  // Shadow trie
  int unsigned trie_link[TRIE_NODES][2];
  int unsigned perm_nodes   = 0;
  int unsigned live_nodes   = 0;
  int unsigned rollback_log[LOG_SLOTS];
  int unsigned rollback_len = 0;

  binary_trie_max_xor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Add a key path; return 1 when the pool or the log cannot hold it
  function automatic bit trie_insert(logic [KEY_W-1:0] key, bit temp);
    int unsigned node;
    int unsigned nxt;
    int unsigned fresh;
    int          lvl;
    bit          side;
    node = 0;
    lvl  = KEY_LEN - 1;
    while (lvl >= 0) begin
      nxt = trie_link[node][key[lvl]];
      if (nxt == 0) break;
      node = nxt;
      lvl--;
    end
    if (lvl < 0) return 1'b0;
    if (live_nodes + lvl + 1 > TRIE_NODES - 1) return 1'b1;
    if (temp && rollback_len + lvl + 1 > LOG_SLOTS) return 1'b1;
    while (lvl >= 0) begin
      side  = key[lvl];
      fresh = live_nodes + 1;
      if (temp) begin
        rollback_log[rollback_len] = (node << 1) | side;
        rollback_len++;
      end
      live_nodes = fresh;
      if (!temp) perm_nodes++;
      trie_link[fresh][0] = 0;
      trie_link[fresh][1] = 0;
      trie_link[node][side] = fresh;
      node = fresh;
      lvl--;
    end
    return 1'b0;
  endfunction

  // Walk down preferring the opposite bit at every level
  function automatic logic [KEY_W-1:0] trie_best_xor(logic [KEY_W-1:0] key);
    int unsigned      node;
    int unsigned      nxt;
    logic [KEY_W-1:0] best;
    bit               want;
    node = 0;
    best = '0;
    for (int lvl = KEY_LEN - 1; lvl >= 0; lvl--) begin
      want = ~key[lvl];
      nxt  = trie_link[node][want];
      if (nxt != 0) best[lvl] = 1'b1;
      else nxt = trie_link[node][~want];
      node = nxt;
    end
    return best;
  endfunction

  // Cut every logged link and free the temporary nodes
  function automatic void trie_rollback();
    int unsigned entry;
    for (int i = 0; i < rollback_len; i++) begin
      entry = rollback_log[i];
      trie_link[entry >> 1][entry & 1] = 0;
    end
    rollback_len = 0;
    live_nodes   = perm_nodes;
  endfunction

  function automatic trie_result_t trie_apply(logic [KIND_W-1:0] kind,
                                              logic [KEY_W-1:0] key);
    trie_result_t res;
    bit           temp;
    res = '0;
    case (kind)
      KIND_CLEAR: begin
        perm_nodes   = 0;
        live_nodes   = 0;
        rollback_len = 0;
        trie_link[0][0] = 0;
        trie_link[0][1] = 0;
      end
      KIND_INS_PERM, KIND_INS_TEMP: begin
        // a permanent insert on top of temporaries is undone with them
        temp = (kind == KIND_INS_TEMP) || (live_nodes != perm_nodes) || (rollback_len != 0);
        res.pool_full = trie_insert(key, temp);
      end
      KIND_QUERY: res.max_xor = trie_best_xor(key);
      KIND_UNDO: trie_rollback();
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic queue_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
    trie_op_t op;
    op.kind = kind;
    op.key  = key;
    pending_ops.push_back(op);
    if (kind <= KIND_UNDO) counted_ops++;
    if (kind == KIND_INS_PERM || kind == KIND_INS_TEMP) seen_keys.push_back(key);
  endtask

  // Mostly random keys, some dense small ones and some close to stored keys
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      sel;
    logic [KEY_W-1:0] k;
    sel = $urandom_range(0, 99);
    k   = KEY_W'($urandom());
    if (sel < 15) begin
      k = KEY_W'($urandom_range(0, 255));
    end else if (sel < 35 && seen_keys.size() > 0) begin
      k = seen_keys[$urandom_range(0, seen_keys.size() - 1)] ^ KEY_W'($urandom_range(0, 15));
    end else if (sel < 38) begin
      k = '1;
    end else if (sel < 41) begin
      k = '0;
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] unknown_kind();
    return KIND_W'($urandom_range(KIND_UNDO + 1, (1 << KIND_W) - 1));
  endfunction

  // Check results and predict each accepted transaction
  always @(posedge clk) begin : check_and_predict
    trie_result_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      perm_nodes   = 0;
      live_nodes   = 0;
      rollback_len = 0;
      trie_link[0][0] = 0;
      trie_link[0][1] = 0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with none pending", out_tdata, '0);
        end else begin
          want = results_due.pop_front();
          if (out_tdata[KEY_W-1:0] !== want.max_xor)
            report_mismatch("max_xor", out_tdata[KEY_W-1:0], want.max_xor);
          if (out_tuser[0] !== want.pool_full)
            report_mismatch("pool_full", out_tuser[0], want.pool_full);
        end
      end
      if (in_tvalid && in_tready) begin
        results_due.push_back(trie_apply(in_tuser, in_tdata[KEY_W-1:0]));
        accepted_items++;
      end
    end
  end

  // Present the next transaction once the current one is gone and the gap is over
  always @(negedge clk) begin : drive_input
    trie_op_t op;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_tdata  <= {{(IN_TDATA_W - KEY_W){1'b0}}, op.key};
        in_tuser  <= op.kind;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 6);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side after each result, and hold off while asked
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (out_taken) recv_stall = send_burst ? 0 : $urandom_range(0, 6);
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !hold_off;
      end
    end
  end

  // Block the result side long enough for the unit to back up its input
  initial begin : long_hold
    while (accepted_items < 60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] first_key;
    int               roll;

    // Directed: empty trie, unknown kinds, extremes, duplicates, undo paths
    queue_op(KIND_QUERY, KEY_W'($urandom()));
    queue_op(KIND_UNDO, '0);
    queue_op(KIND_W'(KIND_UNDO + 1), '1);
    queue_op(unknown_kind(), KEY_W'($urandom()));
    queue_op({KIND_W{1'b1}}, '0);
    queue_op(KIND_INS_PERM, '0);
    queue_op(KIND_INS_PERM, '1);
    queue_op(KIND_QUERY, '0);
    queue_op(KIND_QUERY, '1);
    queue_op(KIND_INS_PERM, '0);
    queue_op(KIND_INS_TEMP, KEY_W'(32'h5555_5555));
    queue_op(KIND_QUERY, KEY_W'(32'h2AAA_AAAA));
    queue_op(KIND_INS_PERM, KEY_W'(32'h1234_5678));
    queue_op(KIND_QUERY, KEY_W'(32'h6DCB_A987));
    queue_op(KIND_UNDO, '1);
    queue_op(KIND_QUERY, KEY_W'(32'h2AAA_AAAA));
    queue_op(KIND_QUERY, KEY_W'(32'h6DCB_A987));
    queue_op(KIND_UNDO, '0);
    queue_op(KIND_CLEAR, '1);
    queue_op(KIND_QUERY, '1);
    queue_op(KIND_INS_TEMP, KEY_W'(32'h4000_0001));
    queue_op(KIND_UNDO, '0);
    queue_op(KIND_QUERY, '0);

    // Overflow the undo log with temporaries, then roll them all back
    queue_op(KIND_CLEAR, '0);
    repeat (400) queue_op(KIND_INS_TEMP, KEY_W'($urandom()));
    queue_op(KIND_INS_PERM, KEY_W'($urandom()));
    repeat (4) queue_op(KIND_QUERY, pick_key());
    queue_op(KIND_UNDO, '0);
    queue_op(KIND_QUERY, KEY_W'($urandom()));

    // Permanent keys, a duplicate, then a temporary layer on top
    queue_op(KIND_CLEAR, '0);
    first_key = KEY_W'($urandom());
    queue_op(KIND_INS_PERM, first_key);
    repeat (20) queue_op(KIND_INS_PERM, KEY_W'($urandom()));
    queue_op(KIND_INS_PERM, first_key);
    queue_op(KIND_INS_TEMP, KEY_W'($urandom()));
    queue_op(KIND_UNDO, '0);
    repeat (4) queue_op(KIND_QUERY, pick_key());
    queue_op(KIND_CLEAR, '0);

    // Random sessions: permanent base, temporary layer, queries, undo
    counted_ops = 0;
    while (counted_ops < RANDOM_OPS) begin
      if ($urandom_range(0, 9) == 0) queue_op(KIND_CLEAR, pick_key());
      repeat ($urandom_range(0, 4)) queue_op(KIND_INS_PERM, pick_key());
      repeat ($urandom_range(0, 3)) queue_op(KIND_QUERY, pick_key());
      repeat ($urandom_range(0, 12)) begin
        roll = $urandom_range(0, 9);
        if (roll < 5) queue_op(KIND_INS_TEMP, pick_key());
        else if (roll < 8) queue_op(KIND_QUERY, pick_key());
        else if (roll == 8) queue_op(KIND_INS_PERM, pick_key());
        else if ($urandom_range(0, 1) == 0) queue_op(unknown_kind(), pick_key());
        else queue_op(KIND_UNDO, pick_key());
      end
      if ($urandom_range(0, 9) < 8) queue_op(KIND_UNDO, pick_key());
      repeat ($urandom_range(0, 3)) queue_op(KIND_QUERY, pick_key());
    end

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all transactions in, all results out, then a short tail
    while (pending_ops.size() != 0 || in_tvalid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
